// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the stable max-priority queue.
package spq_pkg;

   localparam int CAPACITY    = 1024;
   localparam int MAX_RELEASE = 64;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int REMAIN_W    = $clog2(MAX_RELEASE + 1);

   localparam logic [23:0] NUM_MAX = 24'hFFFFFF;

   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [REMAIN_W-1:0] remain_type;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_RELEASE
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] gift_value;
      logic [6:0]  release_count;
   } req_type;

   typedef struct packed {
      logic [23:0] arrival_number;
      logic [31:0] entry_value;
      logic [23:0] release_rank;
      logic        last_of_run;
      logic        overflow_seen;
   } rsp_type;

   typedef struct packed {
      logic [31:0] value;
      logic [23:0] arrival;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage

// ===== hdl/stable_max_priority_queue.sv =====
// Top level: request control, counters and the sorted chain of entry cells.
// Insert and clear: accepted while idle, no result; a release of zero or on an empty
// queue gives none. Release: first result registered from ST_RELEASE, sink permitting,
// then one result per cycle while the sink takes them; the next request is taken the cycle
// after the final result is registered. The chain pops its head with each result.
// Reset clears state, counters and overflow flag at once; cell contents stay undefined.
module stable_max_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);

   localparam int N = spq_pkg::CAPACITY;

   spq_pkg::state_type  state_ff, state_in;
   spq_pkg::count_type  count_ff, count_in;
   spq_pkg::remain_type remain_ff, remain_in;
   logic [23:0]         arrival_ff, arrival_in;
   logic [23:0]         rank_ff, rank_in;
   logic                overflow_ff, overflow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   spq_pkg::cell_ctrl_type ctrl;
   spq_pkg::entry_type     new_entry;
   spq_pkg::entry_type     cell_entry [N];
   logic                   cell_beats [N];
   logic                   cell_occ   [N];

   logic                req_accept;
   logic                pop;
   logic                drop;
   logic [23:0]         rank_next;
   spq_pkg::remain_type cut;

   assign req_stall  = (state_ff != spq_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign pop        = (state_ff == spq_pkg::ST_RELEASE) && (!rsp_valid_ff || !rsp_stall);
   assign drop       = (count_ff >= spq_pkg::count_type'(N)) || (arrival_ff == spq_pkg::NUM_MAX);
   assign rank_next  = (rank_ff < spq_pkg::NUM_MAX) ? rank_ff + 24'd1 : rank_ff;
   assign cut        = (req_data.release_count > 7'(spq_pkg::MAX_RELEASE))
                       ? spq_pkg::remain_type'(spq_pkg::MAX_RELEASE)
                       : spq_pkg::remain_type'(req_data.release_count);

   assign new_entry.value   = req_data.gift_value;
   assign new_entry.arrival = arrival_ff + 24'd1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      arrival_in   = arrival_ff;
      rank_in      = rank_ff;
      overflow_in  = overflow_ff;
      ctrl.insert  = 1'b0;
      ctrl.pop     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.opcode)
                  spq_pkg::OP_INSERT: begin
                     if (drop) begin
                        overflow_in = 1'b1;
                     end else begin
                        ctrl.insert = 1'b1;
                        arrival_in  = arrival_ff + 24'd1;
                        count_in    = count_ff + spq_pkg::count_type'(1);
                     end
                  end
                  spq_pkg::OP_RELEASE: begin
                     remain_in = cut;
                     if ((cut != '0) && (count_ff != '0)) begin
                        state_in = spq_pkg::ST_RELEASE;
                     end
                  end
                  spq_pkg::OP_CLEAR: begin
                     count_in    = '0;
                     arrival_in  = '0;
                     rank_in     = '0;
                     overflow_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         spq_pkg::ST_RELEASE: begin
            if (pop) begin
               ctrl.pop                   = 1'b1;
               rsp_valid_in               = 1'b1;
               rsp_data_in.arrival_number = cell_entry[0].arrival;
               rsp_data_in.entry_value    = cell_entry[0].value;
               rsp_data_in.release_rank   = rank_next;
               rsp_data_in.last_of_run    = (remain_ff == spq_pkg::remain_type'(1))
                                            || (count_ff == spq_pkg::count_type'(1));
               rsp_data_in.overflow_seen  = overflow_ff;
               rank_in                    = rank_next;
               count_in                   = count_ff - spq_pkg::count_type'(1);
               remain_in                  = remain_ff - spq_pkg::remain_type'(1);
               if (rsp_data_in.last_of_run) begin
                  state_in = spq_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         arrival_ff   <= '0;
         rank_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         arrival_ff   <= arrival_in;
         rank_ff      <= rank_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign cell_occ[i] = (count_ff > spq_pkg::count_type'(i));

      if (i == 0) begin : g_head
         spq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .new_entry  (new_entry),
            .prev_entry (new_entry),
            .prev_beats (1'b0),
            .next_entry (cell_entry[i+1]),
            .entry      (cell_entry[i]),
            .beats      (cell_beats[i])
         );
      end else if (i == N - 1) begin : g_tail
         spq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .new_entry  (new_entry),
            .prev_entry (cell_entry[i-1]),
            .prev_beats (cell_beats[i-1]),
            .next_entry (cell_entry[i]),
            .entry      (cell_entry[i]),
            .beats      (cell_beats[i])
         );
      end else begin : g_mid
         spq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .new_entry  (new_entry),
            .prev_entry (cell_entry[i-1]),
            .prev_beats (cell_beats[i-1]),
            .next_entry (cell_entry[i+1]),
            .entry      (cell_entry[i]),
            .beats      (cell_beats[i])
         );
      end
   end

endmodule

// ===== hdl/spq_cell.sv =====
// One cell of the sorted entry chain: holds one entry, shifts on insert and pop.
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  spq_pkg::entry_type     new_entry,
   input  spq_pkg::entry_type     prev_entry,
   input  logic                   prev_beats,
   input  spq_pkg::entry_type     next_entry,
   output spq_pkg::entry_type     entry,
   output logic                   beats
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // ties go behind the stored entry, which arrived earlier
   assign beats = !occupied || (new_entry.value > entry_ff.value);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = next_entry;
      end else if (ctrl.insert && beats) begin
         entry_in = prev_beats ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== dv/spq_checker.sv =====
// Checker for the priority queue: predicts releases from accepted requests, compares results.
`timescale 1ns / 1ps

module spq_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  spq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  spq_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);

   localparam int PRINT_CAP = 100;

   logic [31:0]      held_value   [spq_pkg::CAPACITY];
   logic [23:0]      held_arrival [spq_pkg::CAPACITY];
   int               held_count;
   logic [23:0]      arrival_seq;
   logic [23:0]      rank_seq;
   logic             dropped_flag;
   spq_pkg::rsp_type release_q [$];
   spq_pkg::rsp_type oldest;

   initial begin
      error_count   = 0;
      pending_count = 0;
      held_count    = 0;
      arrival_seq   = '0;
      rank_seq      = '0;
      dropped_flag  = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_CAP)
         $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic apply_request(input spq_pkg::req_type r);
      int               limit;
      int               taken;
      int               best;
      spq_pkg::rsp_type res;
      unique case (r.opcode)
         spq_pkg::OP_INSERT: begin
            if (held_count >= spq_pkg::CAPACITY || arrival_seq >= spq_pkg::NUM_MAX) begin
               dropped_flag = 1'b1;
            end else begin
               arrival_seq = arrival_seq + 24'd1;
               held_value[held_count]   = r.gift_value;
               held_arrival[held_count] = arrival_seq;
               held_count++;
            end
         end
         spq_pkg::OP_RELEASE: begin
            limit = (r.release_count > spq_pkg::MAX_RELEASE) ? spq_pkg::MAX_RELEASE
                                                              : int'(r.release_count);
            taken = 0;
            while (taken < limit && held_count > 0) begin
               best = 0;
               for (int i = 1; i < held_count; i++)
                  if (held_value[i] > held_value[best] ||
                      (held_value[i] == held_value[best] &&
                       held_arrival[i] < held_arrival[best]))
                     best = i;
               if (rank_seq < spq_pkg::NUM_MAX)
                  rank_seq = rank_seq + 24'd1;
               res.arrival_number = held_arrival[best];
               res.entry_value    = held_value[best];
               res.release_rank   = rank_seq;
               res.overflow_seen  = dropped_flag;
               held_count--;
               held_value[best]   = held_value[held_count];
               held_arrival[best] = held_arrival[held_count];
               taken++;
               res.last_of_run = (taken == limit) || (held_count == 0);
               release_q.push_back(res);
            end
         end
         spq_pkg::OP_CLEAR: begin
            held_count   = 0;
            arrival_seq  = '0;
            rank_seq     = '0;
            dropped_flag = 1'b0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count   = 0;
         arrival_seq  = '0;
         rank_seq     = '0;
         dropped_flag = 1'b0;
         release_q.delete();
      end else begin
         if (req_valid && !req_stall)
            apply_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (release_q.size() == 0) begin
               report_mismatch("result with none expected", rsp_data.entry_value, '0);
            end else begin
               oldest = release_q.pop_front();
               if (rsp_data.arrival_number !== oldest.arrival_number)
                  report_mismatch("arrival_number", 32'(rsp_data.arrival_number),
                                  32'(oldest.arrival_number));
               if (rsp_data.entry_value !== oldest.entry_value)
                  report_mismatch("entry_value", rsp_data.entry_value, oldest.entry_value);
               if (rsp_data.release_rank !== oldest.release_rank)
                  report_mismatch("release_rank", 32'(rsp_data.release_rank),
                                  32'(oldest.release_rank));
               if (rsp_data.last_of_run !== oldest.last_of_run)
                  report_mismatch("last_of_run", 32'(rsp_data.last_of_run),
                                  32'(oldest.last_of_run));
               if (rsp_data.overflow_seen !== oldest.overflow_seen)
                  report_mismatch("overflow_seen", 32'(rsp_data.overflow_seen),
                                  32'(oldest.overflow_seen));
            end
         end
      end
      pending_count <= release_q.size();
   end

endmodule

// ===== dv/tb_stable_max_priority_queue.sv =====
// Testbench top for the priority queue: clock, reset, request and stall stimulus, verdict.
`timescale 1ns / 1ps

module tb_stable_max_priority_queue;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         RANDOM_ITEMS = 285;
   localparam int         IDLE_LIMIT   = 1000;
   localparam int         SETTLE_CYCLES = 10;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   spq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   spq_pkg::rsp_type rsp_data;
   int               error_count;
   int               pending_count;
   int               idle_cycles = 0;
   logic             quiet_mode = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stable_max_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   spq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   function automatic logic [31:0] pick_value();
      // narrow range half the time so ties are common
      return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom();
   endfunction

   function automatic logic [6:0] pick_count();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return 7'($urandom_range(0, 6));
      else if (r < 9)
         return 7'($urandom_range(0, spq_pkg::MAX_RELEASE));
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [31:0] value,
                               input logic [6:0] count);
      int               gap;
      spq_pkg::req_type r;
      gap = quiet_mode ? 0 : $urandom_range(0, 8);
      r.opcode        = op;
      r.gift_value    = value;
      r.release_count = count;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = quiet_mode ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int r;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty release, ties, extremes, zero and oversized counts, clear
      send_request(spq_pkg::OP_RELEASE, 32'd0, 7'd5);
      send_request(spq_pkg::OP_INSERT, 32'd5, 7'd0);
      send_request(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 7'd0);
      send_request(spq_pkg::OP_INSERT, 32'd0, 7'd0);
      send_request(spq_pkg::OP_INSERT, 32'd5, 7'd0);
      send_request(spq_pkg::OP_INSERT, 32'h8000_0000, 7'd0);
      send_request(spq_pkg::OP_INSERT, 32'd5, 7'd0);
      send_request(spq_pkg::OP_RELEASE, 32'hFFFF_FFFF, 7'd0);
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 7'd127);
      send_request(spq_pkg::OP_RELEASE, 32'd0, 7'd2);
      send_request(spq_pkg::OP_RELEASE, 32'd0, 7'd127);
      send_request(spq_pkg::OP_RELEASE, 32'd0, 7'd1);
      send_request(spq_pkg::OP_INSERT, 32'd7, 7'd0);
      send_request(spq_pkg::OP_INSERT, 32'd7, 7'd0);
      send_request(spq_pkg::OP_CLEAR, 32'd0, 7'd0);
      send_request(spq_pkg::OP_INSERT, 32'd3, 7'd0);
      send_request(spq_pkg::OP_RELEASE, 32'd0, 7'd64);
      send_request(spq_pkg::OP_RELEASE, 32'd0, 7'd3);

      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0)
            quiet_mode = ~quiet_mode;
         r = $urandom_range(0, 99);
         if (r < 55)
            send_request(spq_pkg::OP_INSERT, pick_value(), 7'($urandom_range(0, 127)));
         else if (r < 88)
            send_request(spq_pkg::OP_RELEASE, $urandom(), pick_count());
         else if (r < 95)
            send_request(spq_pkg::OP_CLEAR, $urandom(), 7'($urandom_range(0, 127)));
         else
            send_request(OP_UNUSED, $urandom(), 7'($urandom_range(0, 127)));
      end

      quiet_mode = 1'b0;
      repeat (spq_pkg::CAPACITY / spq_pkg::MAX_RELEASE + 1)
         send_request(spq_pkg::OP_RELEASE, 32'd0, 7'd64);
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
